// ----- hw/rtl/kcc_pkg.sv -----
// Package for the key click classifier: configuration and result structs,
// item kinds, event codes and register indexes.
// Depends on nothing; used by kcc_core, key_click_classifier_unit and the testbench.
package kcc_pkg;

  // Widths fixed by the item and register layout.
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int KEYS_W      = 4;
  localparam int EVENT_W     = 2;
  localparam int KEY_NUM_W   = 3;
  localparam int COUNT_W     = 8;

  // Defaults for the module parameters.
  localparam int NUM_KEYS_DEF    = 4;
  localparam int TIMER_WIDTH_DEF = 16;

  // Item kinds.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  // Event codes.
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd1;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd80;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] double_window_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [EVENT_W-1:0]   event_code;
    logic [KEY_NUM_W-1:0] key_number;
  } res_t;

endpackage

// ----- hw/rtl/kcc_core.sv -----
// Classifier core: phase machine, hold and window timers, press counter and
// key tracking, stepped once per transaction taken from the input register.
// Depends on kcc_pkg.
module kcc_core import kcc_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              func,
  input  logic [KEYS_W-1:0] keys_n,
  input  cfg_t              cfg,
  output res_t              res
);

  localparam int KEY_LIMIT = (NUM_KEYS < KEYS_W) ? NUM_KEYS : KEYS_W;
  localparam int CMP_W     = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_DECIDE   = 2'd2;
  localparam logic [1:0] PH_RELEASE  = 2'd3;

  logic [1:0]             phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] hold_r, hold_nxt;
  logic [TIMER_WIDTH-1:0] window_r, window_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [KEY_NUM_W-1:0]   cur_key_r, cur_key_nxt;
  logic [KEY_NUM_W-1:0]   prev_key_r, prev_key_nxt;

  logic                   pressed;
  logic [KEY_NUM_W-1:0]   scan_key;
  logic [TIMER_WIDTH-1:0] hold_inc, window_inc;
  logic [CMP_W-1:0]       hold_x, window_x, window_inc_x;
  logic [CMP_W-1:0]       deb_x, dwin_x, long_x;
  logic [EVENT_W-1:0]     code;

  // Saturating increments and common-width operands for the compares.
  assign hold_inc     = (&hold_r) ? hold_r : hold_r + 1'b1;
  assign window_inc   = (&window_r) ? window_r : window_r + 1'b1;
  assign hold_x       = CMP_W'(hold_r);
  assign window_x     = CMP_W'(window_r);
  assign window_inc_x = CMP_W'(window_inc);
  assign deb_x        = CMP_W'(cfg.debounce_ticks);
  assign dwin_x       = CMP_W'(cfg.double_window_ticks);
  assign long_x       = CMP_W'(cfg.long_press_ticks);

  // Lowest-numbered pressed key wins; the descending loop lets it override.
  always_comb begin
    pressed  = 1'b0;
    scan_key = '0;
    for (int i = KEY_LIMIT - 1; i >= 0; i--) begin
      if (!keys_n[i]) begin
        pressed  = 1'b1;
        scan_key = KEY_NUM_W'(i + 1);
      end
    end
  end

  // Next state for one tick or one scan.
  always_comb begin
    phase_nxt    = phase_r;
    hold_nxt     = hold_r;
    window_nxt   = window_r;
    count_nxt    = count_r;
    cur_key_nxt  = cur_key_r;
    prev_key_nxt = prev_key_r;
    code         = EV_NONE;
    if (func == FUNC_TICK) begin
      hold_nxt = hold_inc;
      if (count_r != '0) begin
        window_nxt = window_inc;
        if (window_inc_x > dwin_x && window_inc_x < long_x) begin
          phase_nxt = PH_DECIDE;
        end
      end
    end else begin
      if (pressed) begin
        cur_key_nxt = scan_key;
      end
      unique case (phase_r)
        PH_IDLE: begin
          if (pressed) begin
            hold_nxt  = '0;
            phase_nxt = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (pressed) begin
            if (hold_x >= deb_x) begin
              phase_nxt = PH_DECIDE;
              if (!(&count_r)) begin
                count_nxt = count_r + 1'b1;
              end
            end
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_DECIDE: begin
          if (!pressed) begin
            if (window_x <= dwin_x) begin
              phase_nxt = PH_IDLE;
            end else if (window_x < long_x) begin
              if (count_r == COUNT_W'(1)) begin
                code       = EV_SINGLE;
                phase_nxt  = PH_IDLE;
                count_nxt  = '0;
                window_nxt = '0;
              end else if (count_r >= COUNT_W'(2) && cur_key_nxt == prev_key_r) begin
                code       = EV_DOUBLE;
                phase_nxt  = PH_IDLE;
                count_nxt  = '0;
                window_nxt = '0;
              end
            end
          end else if (hold_x >= long_x) begin
            code      = EV_LONG;
            phase_nxt = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (!pressed) begin
            phase_nxt  = PH_IDLE;
            count_nxt  = '0;
            window_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      prev_key_nxt = cur_key_nxt;
    end
  end

  assign res.event_code = code;
  assign res.key_number = cur_key_nxt;

  // State registers advance only when a transaction is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hold_r     <= '0;
      window_r   <= '0;
      count_r    <= '0;
      cur_key_r  <= '0;
      prev_key_r <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      hold_r     <= hold_nxt;
      window_r   <= window_nxt;
      count_r    <= count_nxt;
      cur_key_r  <= cur_key_nxt;
      prev_key_r <= prev_key_nxt;
    end
  end

endmodule

// ----- hw/rtl/key_click_classifier_unit.sv -----
// Top level of the key click classifier: configuration registers, input
// register, result register and the classifier core.
// Depends on kcc_pkg and kcc_core.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    in_func, in_keys_n
//   out_      output     out_valid/out_ready  out_event_code, out_key_number
//   cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle is taken while the input is not stalled; a scan passes
// through the input register into the result register, where it waits to be taken.
// A tick gives no result.
// The input register moves on whenever the result register is empty or drained
// in the same cycle; a result that waits under a stall blocks a held scan.
// Reset (rst_n low, synchronous) clears valid flags and core, loads register defaults.
// A stalled output holds its result and stops scans; a tick is still processed
// unless a stalled scan sits ahead of it.
module key_click_classifier_unit import kcc_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [KEYS_W-1:0]    in_keys_n,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EVENT_W-1:0]   out_event_code,
  output logic [KEY_NUM_W-1:0] out_key_number,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t                 cfg_r;
  logic                 in_valid_r;
  logic                 func_r;
  logic [KEYS_W-1:0]    keys_r;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 res_r;
  res_t                 res;
  logic                 advance;
  logic                 scan_done;

  // Configuration writes; an unused index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= DEBOUNCE_RST;
      cfg_r.double_window_ticks <= WINDOW_RST;
      cfg_r.long_press_ticks    <= LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks      <= cfg_wdata;
        REG_WINDOW:   cfg_r.double_window_ticks <= cfg_wdata;
        REG_LONG:     cfg_r.long_press_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held transaction is processed when it is a tick or the result slot frees.
  assign advance   = in_valid_r && (func_r == FUNC_TICK || !out_valid_r || out_ready);
  assign scan_done = advance && func_r == FUNC_SCAN;
  assign in_ready  = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r <= in_func;
      keys_r <= in_keys_n;
    end
  end

  kcc_core #(
    .NUM_KEYS    (NUM_KEYS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .func    (func_r),
    .keys_n  (keys_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register.
  always_comb begin
    if (scan_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = res_r.event_code;
  assign out_key_number = res_r.key_number;

  // A processed scan always lands in the result register.
  a_scan_lands: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> out_valid)
    else $error("processed scan did not produce a result");

  // Any event names a key that has been pressed.
  a_event_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_code != EV_NONE) |-> (out_key_number != '0))
    else $error("event reported without a key");

  // Back-pressure on the input only comes from a held scan behind a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && func_r == FUNC_SCAN && out_valid_r && !out_ready))
    else $error("input stalled without cause");

endmodule

// ----- sim/tb_key_click_classifier_unit.sv -----
// Self-checking testbench for key_click_classifier_unit: tick and scan
// transactions with random gaps and stalls, checked against a click predictor.
// Depends on kcc_pkg and the key_click_classifier_unit RTL.
module tb_key_click_classifier_unit;
  import kcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 100_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;
  // The register map has no fourth register; writes to it must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_DECIDE,
    PH_RELEASE
  } click_phase_e;

  // Tracks the classifier state and queues the click event each scan must give.
  class click_tracker;
    cfg_t                       lim;
    click_phase_e               phase;
    logic [TIMER_WIDTH_DEF-1:0] hold_cnt;
    logic [TIMER_WIDTH_DEF-1:0] window_cnt;
    logic [COUNT_W-1:0]         presses;
    logic [KEY_NUM_W-1:0]       active_key;
    logic [KEY_NUM_W-1:0]       last_key;
    res_t                       expected_q[$];
    int                         errors;
    int                         ticks;
    int                         scans;
    int                         seen[4];

    function new();
      lim.debounce_ticks      = DEBOUNCE_RST;
      lim.double_window_ticks = WINDOW_RST;
      lim.long_press_ticks    = LONG_RST;
      phase      = PH_IDLE;
      hold_cnt   = '0;
      window_cnt = '0;
      presses    = '0;
      active_key = '0;
      last_key   = '0;
      errors     = 0;
      ticks      = 0;
      scans      = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE: lim.debounce_ticks = val;
        REG_WINDOW:   lim.double_window_ticks = val;
        REG_LONG:     lim.long_press_ticks = val;
        default: ;
      endcase
    endfunction

    function void clear_window();
      phase      = PH_IDLE;
      presses    = '0;
      window_cnt = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Steps the state for one accepted transaction; a scan queues one event.
    function void take_item(logic func, logic [KEYS_W-1:0] keys);
      bit                 down;
      logic [EVENT_W-1:0] ev;
      res_t               r;
      down = 1'b0;
      ev   = EV_NONE;
      if (func == FUNC_TICK) begin
        ticks++;
        if (hold_cnt != '1) hold_cnt++;
        if (presses != '0) begin
          if (window_cnt != '1) window_cnt++;
          if (window_cnt > lim.double_window_ticks && window_cnt < lim.long_press_ticks)
            phase = PH_DECIDE;
        end
        return;
      end
      scans++;
      // The lowest-numbered pressed key wins; with none pressed the key is kept.
      for (int k = 0; k < NUM_KEYS_DEF && k < KEYS_W; k++) begin
        if (!down && !keys[k]) begin
          down       = 1'b1;
          active_key = KEY_NUM_W'(k + 1);
        end
      end
      case (phase)
        PH_IDLE: begin
          if (down) begin
            hold_cnt = '0;
            phase    = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (!down) begin
            phase = PH_IDLE;
          end else if (hold_cnt >= lim.debounce_ticks) begin
            phase = PH_DECIDE;
            if (presses != '1) presses++;
          end
        end
        PH_DECIDE: begin
          if (!down) begin
            if (window_cnt <= lim.double_window_ticks) begin
              phase = PH_IDLE;
            end else if (window_cnt < lim.long_press_ticks) begin
              if (presses == 1) begin
                ev = EV_SINGLE;
                clear_window();
              end else if (presses >= 2 && active_key == last_key) begin
                ev = EV_DOUBLE;
                clear_window();
              end
            end
          end else if (hold_cnt >= lim.long_press_ticks) begin
            ev    = EV_LONG;
            phase = PH_RELEASE;
          end
        end
        default: begin
          if (!down) clear_window();
        end
      endcase
      last_key     = active_key;
      r.event_code = ev;
      r.key_number = active_key;
      expected_q.push_back(r);
      seen[ev]++;
    endfunction

    // Compares one delivered result with the oldest queued event.
    function void match_event(logic [EVENT_W-1:0] code, logic [KEY_NUM_W-1:0] key);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, event_code=%0d key_number=%0d", $time, code, key);
        return;
      end
      want = expected_q.pop_front();
      if (code !== want.event_code) begin
        errors++;
        $display("%0t: event_code expected %0d, actual %0d", $time, want.event_code, code);
      end
      if (key !== want.key_number) begin
        errors++;
        $display("%0t: key_number expected %0d, actual %0d", $time, want.key_number, key);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_func = FUNC_TICK;
  logic [KEYS_W-1:0]    in_keys_n = '1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [EVENT_W-1:0]   out_event_code;
  logic [KEY_NUM_W-1:0] out_key_number;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  click_tracker clicks = new();
  bit           gaps_on = 1'b1;
  bit           stall_on = 1'b1;
  int           sent = 0;
  int           cycles = 0;

  key_click_classifier_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_keys_n      (in_keys_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .out_key_number (out_key_number),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Result side: check every delivered transaction and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) clicks.match_event(out_event_code, out_key_number);
    out_ready <= rst_n && !(stall_on && $urandom_range(0, 99) < 9);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_key_click_classifier_unit: FAIL");
      $finish;
    end
  end

  // Offers one transaction, with an optional random gap, and waits for acceptance.
  task automatic send_item(input logic func, input logic [KEYS_W-1:0] keys);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_keys_n <= keys;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    clicks.take_item(func, keys);
    sent++;
  endtask

  task automatic tick(input int n);
    repeat (n) send_item(FUNC_TICK, KEYS_W'($urandom));
  endtask

  task automatic scan(input logic [KEYS_W-1:0] keys);
    send_item(FUNC_SCAN, keys);
  endtask

  // Lets the block run empty: all results in, then time for a trailing tick.
  task automatic settle();
    in_valid <= 1'b0;
    while (clicks.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] win,
                            input logic [CFG_W-1:0] lng, input bit spare);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    clicks.write_reg(REG_DEBOUNCE, deb);
    cfg_index <= REG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    clicks.write_reg(REG_WINDOW, win);
    cfg_index <= REG_LONG;
    cfg_wdata <= lng;
    @(posedge clk);
    clicks.write_reg(REG_LONG, lng);
    if (spare) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= junk;
      @(posedge clk);
      clicks.write_reg(REG_UNUSED, junk);
    end
    cfg_we <= 1'b0;
  endtask

  // A press/release walk on a key grip that may change, with tick runs of random length in between.
  task automatic click_gesture();
    logic [KEYS_W-1:0] grip;
    int                segs;
    int                span;
    int                n;
    bit                held;
    grip = ~(KEYS_W'(1) << $urandom_range(0, KEYS_W - 1));
    if ($urandom_range(0, 4) == 0) grip &= KEYS_W'($urandom);
    span = int'(clicks.lim.long_press_ticks) + 3;
    if (span > 40) span = 40;
    segs = $urandom_range(2, 10);
    held = 1'b0;
    repeat (segs) begin
      n = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 2) : $urandom_range(0, span);
      tick(n);
      if ($urandom_range(0, 9) < 6) held = !held;
      if ($urandom_range(0, 9) == 0) grip = ~(KEYS_W'(1) << $urandom_range(0, KEYS_W - 1));
      scan(held ? grip : '1);
    end
  endtask

  initial begin
    int budget;
    int start;
    logic [CFG_W-1:0] win;
    logic [CFG_W-1:0] lng;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle scan before any press, then a single, a double and a long press.
    set_limits(16'd1, 16'd2, 16'd5, 1'b1);
    scan(4'hF);
    tick(1);
    scan(4'h0);
    tick(1);
    scan(4'b1101);
    scan(4'hF);
    tick(3);
    scan(4'hF);
    scan(4'b1011);
    tick(1);
    scan(4'b1011);
    scan(4'hF);
    scan(4'b1011);
    tick(1);
    scan(4'b1011);
    scan(4'hF);
    tick(2);
    scan(4'hF);
    scan(4'b0111);
    tick(1);
    scan(4'b0111);
    tick(4);
    scan(4'b0111);
    scan(4'hF);

    // Saturation: press counter past its top, then a short hold at full-scale limits.
    set_limits('0, '1, '1, 1'b0);
    repeat (260) begin
      scan(4'b1110);
      scan(4'b1110);
      scan(4'hF);
    end
    scan(4'b1110);
    scan(4'b1110);
    tick(4);
    scan(4'b1110);
    scan(4'hF);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_limits('0, '0, '0, 1'b1);
        1: set_limits('1, '1, '1, 1'b0);
        default: begin
          win = CFG_W'($urandom_range(0, 8));
          lng = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 10))
                                            : CFG_W'($urandom_range(win, win + 15));
          set_limits(CFG_W'($urandom_range(0, 3)), win, lng, ph % 3 == 0);
        end
      endcase
      // One phase runs with no gaps and no stalls at all.
      gaps_on  = (ph != 5);
      stall_on = (ph != 5);
      budget = (ph < 2) ? 40 : 75;
      start  = sent;
      while (sent - start < budget) begin
        if ($urandom_range(0, 99) < 85) begin
          click_gesture();
        end else begin
          repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), KEYS_W'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (clicks.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Covered %0d ticks and %0d scans under 12 register settings.",
             clicks.ticks, clicks.scans);
    $display("Events seen: %0d none, %0d single, %0d double, %0d long press.",
             clicks.seen[EV_NONE], clicks.seen[EV_SINGLE], clicks.seen[EV_DOUBLE],
             clicks.seen[EV_LONG]);
    if (clicks.errors == 0) begin
      $display("tb_key_click_classifier_unit: PASS");
    end else begin
      $display("tb_key_click_classifier_unit: FAIL");
    end
    $finish;
  end

endmodule
